/* rtl/core/cls_pkg.sv */
package cls_pkg;

  // field widths of the stream items
  localparam int unsigned OPCODE_BITS = 2;
  localparam int unsigned POS_BITS    = 6;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned COUNT_BITS  = 7;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // ram read address source
  typedef enum logic [1:0] {
    RD_POS       = 2'd0,
    RD_POS_NEXT  = 2'd1,
    RD_CUR_NEXT2 = 2'd2
  } rd_sel_e;

  // ram write address and data source
  typedef enum logic {
    WR_APPEND = 1'b0,
    WR_SHIFT  = 1'b1
  } wr_sel_e;

  // result word source
  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_ONES  = 2'd1,
    RES_RDATA = 2'd2
  } res_sel_e;

  typedef struct packed {
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     cur_load;
    logic     cur_inc;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     stage_load;
    res_sel_e res_sel;
    status_e  res_status;
  } cmd_t;

  typedef struct packed {
    logic stage_full;
    logic full;
    logic pos_bad;
    logic rem_last;
    logic shift_last;
  } sts_t;

endpackage

/* rtl/core/cls_ram.sv */
module cls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/cls_ctrl.sv */
module cls_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cls_pkg::OPCODE_BITS-1:0]   opcode_i,
  input  cls_pkg::sts_t                     sts_i,
  output cls_pkg::cmd_t                     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && !sts_i.stage_full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o            = '0;
    cmd_o.rd_sel     = cls_pkg::RD_POS;
    cmd_o.wr_sel     = cls_pkg::WR_APPEND;
    cmd_o.res_sel    = cls_pkg::RES_ZERO;
    cmd_o.res_status = cls_pkg::ST_OK;
    state_d          = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cls_pkg::opcode_e'(opcode_i))
            cls_pkg::OP_APPEND: begin
              cmd_o.stage_load = 1'b1;
              if (sts_i.full) begin
                cmd_o.res_status = cls_pkg::ST_FULL;
              end else begin
                cmd_o.wr_en   = 1'b1;
                cmd_o.cnt_inc = 1'b1;
              end
            end
            cls_pkg::OP_READ: begin
              if (sts_i.pos_bad) begin
                cmd_o.stage_load = 1'b1;
                cmd_o.res_sel    = cls_pkg::RES_ONES;
                cmd_o.res_status = cls_pkg::ST_BAD_INDEX;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d     = S_READ;
              end
            end
            cls_pkg::OP_REMOVE: begin
              if (sts_i.pos_bad) begin
                cmd_o.stage_load = 1'b1;
                cmd_o.res_status = cls_pkg::ST_BAD_INDEX;
              end else if (sts_i.rem_last) begin
                // removing the tail entry needs no shifting
                cmd_o.cnt_dec    = 1'b1;
                cmd_o.stage_load = 1'b1;
              end else begin
                cmd_o.cur_load = 1'b1;
                cmd_o.rd_en    = 1'b1;
                cmd_o.rd_sel   = cls_pkg::RD_POS_NEXT;
                state_d        = S_SHIFT;
              end
            end
            default: begin
              cmd_o.stage_load = 1'b1;
              cmd_o.res_status = cls_pkg::ST_BAD_INDEX;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.stage_load = 1'b1;
        cmd_o.res_sel    = cls_pkg::RES_RDATA;
        state_d          = S_IDLE;
      end
      S_SHIFT: begin
        // write the entry fetched last cycle one place down, fetch the next
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = cls_pkg::WR_SHIFT;
        cmd_o.cur_inc = 1'b1;
        if (sts_i.shift_last) begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.stage_load = 1'b1;
          state_d          = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = cls_pkg::RD_CUR_NEXT2;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/cls_dpath.sv */
module cls_dpath #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cls_pkg::cmd_t                     cmd_i,
  output cls_pkg::sts_t                     sts_o,
  input  logic [cls_pkg::POS_BITS-1:0]      position_i,
  input  logic signed [cls_pkg::VALUE_BITS-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [cls_pkg::VALUE_BITS-1:0] read_word_o,
  output logic [cls_pkg::STATUS_BITS-1:0]   status_o,
  output logic [cls_pkg::COUNT_BITS-1:0]    entry_count_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > cls_pkg::POS_BITS) ? CW : cls_pkg::POS_BITS) + 1;

  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   cur_q, cur_d;
  logic [CMPW-1:0] pos_ext, pos_nxt, count_ext, cur_ext;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  logic signed [cls_pkg::VALUE_BITS-1:0] res_word;

  logic signed [cls_pkg::VALUE_BITS-1:0] stage_word_q, out_word_q;
  cls_pkg::status_e                      stage_status_q, out_status_q;
  logic [cls_pkg::COUNT_BITS-1:0]        stage_cnt_q, out_cnt_q;
  logic                                  stage_valid_q, stage_valid_d;
  logic                                  out_valid_q, out_valid_d;
  logic                                  out_move;

  assign pos_ext   = CMPW'(position_i);
  assign pos_nxt   = pos_ext + CMPW'(1);
  assign count_ext = CMPW'(count_q);
  assign cur_ext   = CMPW'(cur_q);

  assign sts_o.stage_full = stage_valid_q;
  assign sts_o.full       = (count_q == CW'(DEPTH));
  assign sts_o.pos_bad    = (pos_ext >= count_ext);
  assign sts_o.rem_last   = (pos_nxt == count_ext);
  assign sts_o.shift_last = ((cur_ext + CMPW'(2)) == count_ext);

  always_comb begin
    case (cmd_i.rd_sel)
      cls_pkg::RD_POS:       rd_addr = pos_ext[AW-1:0];
      cls_pkg::RD_POS_NEXT:  rd_addr = pos_nxt[AW-1:0];
      cls_pkg::RD_CUR_NEXT2: rd_addr = cur_q + AW'(2);
      default:               rd_addr = pos_ext[AW-1:0];
    endcase
  end

  assign rd_en = cmd_i.rd_en;

  always_comb begin
    case (cmd_i.wr_sel)
      cls_pkg::WR_APPEND: begin
        wr_addr = count_q[AW-1:0];
        wr_data = WORD_BITS'(value_i);
      end
      cls_pkg::WR_SHIFT: begin
        wr_addr = cur_q;
        wr_data = rd_data;
      end
      default: begin
        wr_addr = cur_q;
        wr_data = rd_data;
      end
    endcase
  end

  cls_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    cur_d = cur_q;
    if (cmd_i.cur_load) begin
      cur_d = pos_ext[AW-1:0];
    end else if (cmd_i.cur_inc) begin
      cur_d = cur_q + AW'(1);
    end
  end

  // result word: zero, all ones, or the stored word sign-extended or cut to the 32-bit result
  always_comb begin
    case (cmd_i.res_sel)
      cls_pkg::RES_ZERO:  res_word = '0;
      cls_pkg::RES_ONES:  res_word = '1;
      cls_pkg::RES_RDATA: res_word = cls_pkg::VALUE_BITS'($signed(rd_data));
      default:            res_word = '0;
    endcase
  end

  // staging register in front of the output register
  assign out_move = stage_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (cmd_i.stage_load) begin
      stage_valid_d = 1'b1;
    end else if (out_move) begin
      stage_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      count_q       <= count_d;
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.stage_load) begin
      stage_word_q   <= res_word;
      stage_status_q <= cmd_i.res_status;
      stage_cnt_q    <= cls_pkg::COUNT_BITS'(count_d);
    end
    if (out_move) begin
      out_word_q   <= stage_word_q;
      out_status_q <= stage_status_q;
      out_cnt_q    <= stage_cnt_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_word_o   = out_word_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_cnt_q;

`ifndef NO_ASSERTIONS
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond capacity");

  a_stage_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.stage_load |-> !stage_valid_q)
    else $error("result staged over a waiting one");

  a_append_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> count_q == $past(count_q) + CW'(1))
    else $error("append did not grow the count");

  a_shift_inside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && cmd_i.wr_sel == cls_pkg::WR_SHIFT) |-> (cur_ext + CMPW'(1) < count_ext))
    else $error("shift write outside the held entries");
`endif

endmodule

/* rtl/core/compacting_list_store_core.sv */
// channel  | dir | tdata (lsb up)                      | tuser
// s_axis   | in  | position[5:0], value[37:6]          | opcode[1:0]
// m_axis   | out | read_word[31:0], entry_count[38:32] | status[1:0]
//
// append and every rejected request: result goes through the staging and output registers
// read: result goes through the registered ram read, then the staging and output registers
// remove at p with n entries: entries p+1 to n-1 move one place down, one entry per
// cycle through the ram's single write port; a tail remove behaves like an append
// next transfer needs an idle controller and a drained staging register
// reset clears the count, controller state and valid flags; entry storage is left as it is
module compacting_list_store_core #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position, value
  input  logic [1:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_word, entry_count
  output logic [1:0]  m_axis_tuser    // status
);

  cls_pkg::cmd_t cmd;
  cls_pkg::sts_t sts;

  logic signed [cls_pkg::VALUE_BITS-1:0] read_word;
  logic [cls_pkg::COUNT_BITS-1:0]        entry_count;

  cls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cls_dpath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .position_i    (s_axis_tdata[5:0]),
    .value_i       (s_axis_tdata[37:6]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .read_word_o   (read_word),
    .status_o      (m_axis_tuser),
    .entry_count_o (entry_count)
  );

  assign m_axis_tdata = {1'b0, entry_count, read_word};

endmodule
